// ===== design/assert_macros.svh =====
// assertion macros shared by the reorder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/thr_pkg.sv =====
// shared constants and field widths of the tile to full hermitian reorder unit
package thr_pkg;

  // default array size
  localparam int DEF_STATIONS      = 32;
  localparam int DEF_FREQ_CHANNELS = 16;

  // field widths
  localparam int KIND_W  = 1;
  localparam int IDX_W   = 17;
  localparam int WORD_W  = 32;
  localparam int FREQ_W  = 4;
  localparam int STA_W   = 5;
  localparam int POL_W   = 1;

  // item kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

  // float sign bit
  localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

endpackage

// ===== design/tile_to_full_hermitian_reorder_unit.sv =====
// top level: tile dump store and full-matrix visibility read pipeline
`include "assert_macros.svh"

// Reorder buffer between a register-tile correlator dump and a full
// hermitian visibility matrix. Load words (in_kind = 0) write one float word
// of the dump, real plane first, then imaginary plane; read words
// (in_kind = 1) return one full-matrix element, taken from the mirrored
// lower-triangle entry with the imaginary sign flipped when it is conjugated.
// The unit takes one word per clock while in_stall is low and presents a
// read result on out_valid through four registers (input register, address
// terms, address sum, memory read). The store is two plane
// memories of FREQ_CHANNELS*16*QUAD words each,
// QUAD = (STATIONS/2+1)*(STATIONS/4); each memory has one address per cycle,
// used by the single word in the memory stage. The store is not cleared:
// an entry must be loaded before it is read. Loads cause no result; reads
// with a channel or station out of range are dropped. When a result is held
// on out_stall the whole pipeline holds, and in_stall follows.
module tile_to_full_hermitian_reorder_unit #(
  parameter int STATIONS      = thr_pkg::DEF_STATIONS,
  parameter int FREQ_CHANNELS = thr_pkg::DEF_FREQ_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [thr_pkg::KIND_W-1:0]  in_kind,
  input  logic [thr_pkg::IDX_W-1:0]   in_word_index,
  input  logic [thr_pkg::WORD_W-1:0]  in_word_value,
  input  logic [thr_pkg::FREQ_W-1:0]  in_freq_channel,
  input  logic [thr_pkg::STA_W-1:0]   in_row_station,
  input  logic [thr_pkg::STA_W-1:0]   in_col_station,
  input  logic [thr_pkg::POL_W-1:0]   in_row_pol,
  input  logic [thr_pkg::POL_W-1:0]   in_col_pol,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [thr_pkg::WORD_W-1:0]  out_real_bits,
  output logic [thr_pkg::WORD_W-1:0]  out_imag_bits,
  output logic                        out_conjugated
);
  import thr_pkg::*;

  // store geometry
  localparam int QUAD  = (STATIONS / 2 + 1) * (STATIONS / 4);
  localparam int PLANE = FREQ_CHANNELS * 16 * QUAD;
  localparam int DEPTH = 2 * PLANE;
  localparam int AW    = $clog2(PLANE);
  localparam int RW    = AW + 1;
  localparam int TRI_W = 2 * (STA_W - 1);

  localparam logic [31:0]   PLANE_W = 32'(PLANE);
  localparam logic [31:0]   DEPTH_W = 32'(DEPTH);
  localparam logic [RW-1:0] FQ_K    = RW'(4 * QUAD);
  localparam logic [RW-1:0] QUAD_K  = RW'(QUAD);
  localparam logic [RW-1:0] PLANE_R = RW'(PLANE);

  // pipeline advance: hold everything while a result waits on out_stall
  logic adv;

  // stage 1: input register with entry choice
  logic                s1_v_r;
  logic                s1_load_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic [WORD_W-1:0]   s1_wdata_r;
  logic [FREQ_W-1:0]   s1_f_r;
  logic [STA_W-1:0]    s1_s_r;
  logic [STA_W-1:0]    s1_t_r;
  logic                s1_p1_r;
  logic                s1_p2_r;
  logic                s1_conj_r;
  logic                rd_ok;
  logic                direct;

  // stage 2: address terms
  logic                s2_v_r;
  logic                s2_load_r;
  logic                s2_sel_re_r;
  logic [AW-1:0]       s2_laddr_r;
  logic [WORD_W-1:0]   s2_wdata_r;
  logic [RW-1:0]       s2_term_f_r;
  logic [RW-1:0]       s2_term_q_r;
  logic [RW-1:0]       s2_term_ij_r;
  logic [1:0]          s2_pol_r;
  logic                s2_conj_r;
  logic                s1_in_depth;
  logic                s1_in_plane;
  logic [31:0]         s1_idx_ext;
  logic [31:0]         s1_idx_imag;
  logic [STA_W-2:0]    s1_i;
  logic [TRI_W-1:0]    s1_tri;

  // stage 3: memory address
  logic                s3_v_r;
  logic                s3_load_r;
  logic                s3_sel_re_r;
  logic [AW-1:0]       s3_addr_r;
  logic [WORD_W-1:0]   s3_wdata_r;
  logic                s3_inrange_r;
  logic                s3_conj_r;
  logic [RW-1:0]       s2_l;
  logic [RW-1:0]       s2_r;

  // stage 4: memory data, output register
  logic                out_v_r;
  logic [WORD_W-1:0]   rd_re_r;
  logic [WORD_W-1:0]   rd_im_r;
  logic                s4_inrange_r;
  logic                s4_conj_r;

  // plane memories
  logic [WORD_W-1:0]   mem_re [PLANE];
  logic [WORD_W-1:0]   mem_im [PLANE];

  assign adv      = !(out_v_r && out_stall);
  assign in_stall = !adv;

  // range check and choice of the lower-triangle entry
  always_comb begin
    rd_ok  = (32'(in_freq_channel) < 32'(FREQ_CHANNELS)) &&
             (32'(in_row_station) < 32'(STATIONS)) &&
             (32'(in_col_station) < 32'(STATIONS));
    direct = (in_row_station > in_col_station) ||
             ((in_row_station == in_col_station) && in_row_pol[0] && !in_col_pol[0]);
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid && ((in_kind == KIND_LOAD) || rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_load_r  <= (in_kind == KIND_LOAD);
      s1_idx_r   <= in_word_index;
      s1_wdata_r <= in_word_value;
      s1_f_r     <= in_freq_channel;
      s1_s_r     <= direct ? in_row_station : in_col_station;
      s1_t_r     <= direct ? in_col_station : in_row_station;
      s1_p1_r    <= direct ? in_row_pol[0] : in_col_pol[0];
      s1_p2_r    <= direct ? in_col_pol[0] : in_row_pol[0];
      s1_conj_r  <= !direct;
    end
  end

  // load plane select and triangle offset
  always_comb begin
    s1_idx_ext  = 32'(s1_idx_r);
    s1_in_depth = s1_idx_ext < DEPTH_W;
    s1_in_plane = s1_idx_ext < PLANE_W;
    s1_idx_imag = s1_idx_ext - PLANE_W;
    s1_i        = s1_s_r[STA_W-1:1];
    s1_tri      = TRI_W'((TRI_W'(s1_i) * (TRI_W'(s1_i) + TRI_W'(1))) >> 1);
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && (!s1_load_r || s1_in_depth);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_load_r    <= s1_load_r;
      s2_sel_re_r  <= s1_in_plane;
      s2_laddr_r   <= s1_in_plane ? s1_idx_ext[AW-1:0] : s1_idx_imag[AW-1:0];
      s2_wdata_r   <= s1_wdata_r;
      s2_term_f_r  <= RW'(s1_f_r) * FQ_K;
      s2_term_q_r  <= RW'({s1_t_r[0], s1_s_r[0]}) * QUAD_K;
      s2_term_ij_r <= RW'(s1_tri) + RW'(s1_t_r[STA_W-1:1]);
      s2_pol_r     <= {s1_p1_r, s1_p2_r};
      s2_conj_r    <= s1_conj_r;
    end
  end

  // tile address sum
  always_comb begin
    s2_l = s2_term_f_r + s2_term_q_r + s2_term_ij_r;
    s2_r = {s2_l[RW-3:0], s2_pol_r};
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_load_r    <= s2_load_r;
      s3_sel_re_r  <= s2_sel_re_r;
      s3_addr_r    <= s2_load_r ? s2_laddr_r : s2_r[AW-1:0];
      s3_wdata_r   <= s2_wdata_r;
      s3_inrange_r <= s2_r < PLANE_R;
      s3_conj_r    <= s2_conj_r;
    end
  end

  // plane memories: one read and at most one write per cycle each while the pipeline advances, at one address
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_v_r && s3_load_r && s3_sel_re_r) begin
        mem_re[s3_addr_r] <= s3_wdata_r;
      end
      rd_re_r <= mem_re[s3_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_v_r && s3_load_r && !s3_sel_re_r) begin
        mem_im[s3_addr_r] <= s3_wdata_r;
      end
      rd_im_r <= mem_im[s3_addr_r];
    end
  end

  // stage 4 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s3_v_r && !s3_load_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_inrange_r <= s3_inrange_r;
      s4_conj_r    <= s3_conj_r;
    end
  end

  // result word
  assign out_valid      = out_v_r;
  assign out_conjugated = s4_conj_r;
  assign out_real_bits  = s4_inrange_r ? rd_re_r : '0;
  assign out_imag_bits  = (s4_inrange_r ? rd_im_r : '0) ^ (s4_conj_r ? SIGN_BIT : '0);

  // checks
  `ASSERT_CLK(a_stall_only_on_held_result, in_stall |-> (out_v_r && out_stall), "input stalled without a held result")
  `ASSERT_CLK(a_load_always_enters, (in_valid && !in_stall && in_kind == KIND_LOAD) |=> s1_v_r, "accepted load word lost at stage 1")
  `ASSERT_ALWAYS(a_read_no_write, (s3_v_r && !s3_load_r) |-> !(s3_load_r && s3_sel_re_r), "read word drives a memory write")

endmodule
